// ----- hdl/bca_pkg.sv -----
package bca_pkg;

    localparam int WORD_BITS     = 32;
    localparam int POS_W         = 5;
    localparam int LEN_W         = 6;
    localparam int COUNT_W       = 11;
    localparam int RUN_W         = 12;
    localparam int START_W       = 10;
    localparam int FOUND_W       = 10;
    localparam int ADDR_W        = 32;
    localparam int SHIFT_W       = 5;
    localparam int CFG_INDEX_W   = 1;
    localparam int UNITS_DEFAULT = 1024;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RESERVE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_SHIFT   = 1'b1;

    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] count;
        logic [START_W-1:0] start_index;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [FOUND_W-1:0] found_index;
        logic [ADDR_W-1:0]  address;
    } rsp_t;

    typedef struct packed {
        logic             hit;
        logic [RUN_W-1:0] run_out;
    } scan_t;

    // units past the end of the map are held as used
    function automatic logic [WORD_BITS-1:0] pad_word(input int units, input int idx);
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int p = 0; p < WORD_BITS; p++)
        begin
            w[p] = ((idx * WORD_BITS + p) >= units);
        end
        return w;
    endfunction

endpackage

// ----- hdl/bitmap_contiguous_allocator.sv -----
// First-fit allocator over a bitmap of UNITS units, held as a ring of 32-bit cells that
// rotates one word per cycle, while scanning or marking, past a single scan head. An
// allocate item takes one rotation of NW = ceil(UNITS/32) words to find the first free
// run and, on success, a second rotation to mark it; a failed allocate ends after the scan,
// a reserve marks in a single rotation, and a zero-count allocate or a reserve outside the
// map goes straight to done. busy stays high until the cycle after done. done is high for
// exactly one cycle and the receiver cannot stall it. The map is free after reset, with
// no clearing pass; the user must write configuration only while busy is low (not enforced).
module bitmap_contiguous_allocator #(
    parameter int UNITS = bca_pkg::UNITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bca_pkg::req_t                     req,
    output logic                              done,
    output bca_pkg::rsp_t                     rsp,
    input  logic                              cfg_we,
    input  logic [bca_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bca_pkg::ADDR_W-1:0]        cfg_data
);

    localparam int NW  = (UNITS + bca_pkg::WORD_BITS - 1) / bca_pkg::WORD_BITS;
    localparam int WCW = (NW > 1) ? $clog2(NW) : 1;
    localparam int IW  = $clog2(UNITS);
    localparam logic [WCW-1:0] LAST_WORD = WCW'(NW - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MARK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [bca_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [IW-1:0]                 first_reg, first_next;
    logic [bca_pkg::RUN_W-1:0]     run_reg, run_next;
    logic [WCW-1:0]                wcnt_reg, wcnt_next;
    logic                          found_reg, found_next;
    logic                          ok_reg, ok_next;
    logic [bca_pkg::ADDR_W-1:0]    base_reg;
    logic [bca_pkg::SHIFT_W-1:0]   shift_reg;

    logic [bca_pkg::WORD_BITS-1:0] ring_q [NW];
    logic [bca_pkg::WORD_BITS-1:0] feed;
    logic [bca_pkg::WORD_BITS-1:0] mark_mask;
    logic [IW-1:0]                 hit_start;
    logic [bca_pkg::ADDR_W-1:0]    first32;
    logic                          rotate;
    bca_pkg::scan_t                scan;

    assign rotate = (state_reg == ST_SCAN) || (state_reg == ST_MARK);
    assign feed   = (state_reg == ST_MARK) ? (ring_q[0] | mark_mask) : ring_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < NW; gi++)
        begin : g_cell
            localparam logic [bca_pkg::WORD_BITS-1:0] RW = bca_pkg::pad_word(UNITS, gi);
            if (gi == NW - 1)
            begin : g_tail
                bca_cell #(.RESET_WORD(RW)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (rotate),
                    .d     (feed),
                    .q     (ring_q[gi])
                );
            end
            else
            begin : g_body
                bca_cell #(.RESET_WORD(RW)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (rotate),
                    .d     (ring_q[gi+1]),
                    .q     (ring_q[gi])
                );
            end
        end
    endgenerate

    bca_scan #(.UNITS(UNITS)) u_scan (
        .word      (ring_q[0]),
        .run_in    (run_reg),
        .count     (count_reg),
        .word_idx  (wcnt_reg),
        .first     (first_reg),
        .scan      (scan),
        .hit_start (hit_start),
        .mark_mask (mark_mask)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        first_next = first_reg;
        run_next   = run_reg;
        wcnt_next  = wcnt_reg;
        found_next = found_reg;
        ok_next    = ok_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    count_next = req.count;
                    run_next   = '0;
                    wcnt_next  = '0;
                    found_next = 1'b0;
                    if (req.cmd == bca_pkg::CMD_ALLOC)
                    begin
                        if (req.count == '0)
                        begin
                            ok_next    = 1'b1;
                            first_next = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (32'(req.start_index) >= 32'(UNITS))
                    begin
                        ok_next    = 1'b0;
                        first_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ok_next    = 1'b1;
                        first_next = IW'(req.start_index);
                        state_next = ST_MARK;
                    end
                end
            end
            ST_SCAN:
            begin
                run_next  = scan.run_out;
                wcnt_next = wcnt_reg + 1'b1;
                if (!found_reg && scan.hit)
                begin
                    found_next = 1'b1;
                    first_next = hit_start;
                end
                if (wcnt_reg == LAST_WORD)
                begin
                    wcnt_next = '0;
                    if (found_reg || scan.hit)
                    begin
                        ok_next    = 1'b1;
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        first_next = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MARK:
            begin
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == LAST_WORD)
                begin
                    wcnt_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wcnt_reg  <= '0;
            found_reg <= 1'b0;
            ok_reg    <= 1'b0;
            first_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wcnt_reg  <= wcnt_next;
            found_reg <= found_next;
            ok_reg    <= ok_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        run_reg   <= run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= bca_pkg::BASE_RESET;
            shift_reg <= bca_pkg::SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bca_pkg::REG_BASE_ADDRESS: base_reg  <= cfg_data;
                bca_pkg::REG_UNIT_SHIFT:   shift_reg <= cfg_data[bca_pkg::SHIFT_W-1:0];
                default:                   base_reg  <= base_reg;
            endcase
        end
    end

    assign first32 = 32'(first_reg);

    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_DONE);
    assign rsp.ok          = ok_reg;
    assign rsp.found_index = first32[bca_pkg::FOUND_W-1:0];
    assign rsp.address     = ok_reg ? (base_reg + (first32 << shift_reg)) : '0;

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |-> (rsp.address == '0 && rsp.found_index == '0))
        else $error("failed item carries nonzero index or address");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) |-> ok_reg)
        else $error("marking pass without success");

endmodule

// ----- hdl/bca_cell.sv -----
module bca_cell #(
    parameter logic [bca_pkg::WORD_BITS-1:0] RESET_WORD = '0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic [bca_pkg::WORD_BITS-1:0] d,
    output logic [bca_pkg::WORD_BITS-1:0] q
);

    logic [bca_pkg::WORD_BITS-1:0] word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= RESET_WORD;
        end
        else if (shift)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

// ----- hdl/bca_scan.sv -----
module bca_scan #(
    parameter int UNITS  = bca_pkg::UNITS_DEFAULT,
    localparam int NW  = (UNITS + bca_pkg::WORD_BITS - 1) / bca_pkg::WORD_BITS,
    localparam int WCW = (NW > 1) ? $clog2(NW) : 1,
    localparam int IW  = $clog2(UNITS)
) (
    input  logic [bca_pkg::WORD_BITS-1:0] word,
    input  logic [bca_pkg::RUN_W-1:0]     run_in,
    input  logic [bca_pkg::COUNT_W-1:0]   count,
    input  logic [WCW-1:0]                word_idx,
    input  logic [IW-1:0]                 first,
    output bca_pkg::scan_t                scan,
    output logic [IW-1:0]                 hit_start,
    output logic [bca_pkg::WORD_BITS-1:0] mark_mask
);

    localparam int GW  = WCW + bca_pkg::POS_W;
    localparam int SW  = ((GW > bca_pkg::COUNT_W) ? GW : bca_pkg::COUNT_W) + 2;
    localparam int WB  = bca_pkg::WORD_BITS;

    logic [bca_pkg::LEN_W-1:0] len_s [0:bca_pkg::POS_W][0:WB-1];
    logic [bca_pkg::RUN_W-1:0] total [0:WB-1];
    logic [WB-1:0]             hit_vec;
    logic [bca_pkg::POS_W-1:0] hit_pos;
    logic [SW-1:0]             start_sum;
    logic [SW-1:0]             end_sum;
    logic [SW-1:0]             gpos;

    // free run ending at each bit, by doubling windows
    always_comb
    begin
        for (int p = 0; p < WB; p++)
        begin
            len_s[0][p] = bca_pkg::LEN_W'(!word[p]);
        end
        for (int k = 0; k < bca_pkg::POS_W; k++)
        begin
            for (int p = 0; p < WB; p++)
            begin
                if (p >= (1 << k) && len_s[k][p] == bca_pkg::LEN_W'(1 << k))
                begin
                    len_s[k+1][p] = bca_pkg::LEN_W'(1 << k)
                                  + len_s[k][(p >= (1 << k)) ? p - (1 << k) : 0];
                end
                else
                begin
                    len_s[k+1][p] = len_s[k][p];
                end
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < WB; p++)
        begin
            if (len_s[bca_pkg::POS_W][p] == bca_pkg::LEN_W'(p + 1))
            begin
                total[p] = run_in + bca_pkg::RUN_W'(p + 1);
            end
            else
            begin
                total[p] = bca_pkg::RUN_W'(len_s[bca_pkg::POS_W][p]);
            end
            hit_vec[p] = (total[p] >= bca_pkg::RUN_W'(count));
        end
        hit_pos = '0;
        for (int p = WB - 1; p >= 0; p--)
        begin
            if (hit_vec[p])
            begin
                hit_pos = bca_pkg::POS_W'(p);
            end
        end
    end

    assign scan.hit     = |hit_vec;
    assign scan.run_out = total[WB-1];

    assign start_sum = SW'({word_idx, hit_pos}) + SW'(1) - SW'(count);
    assign hit_start = start_sum[IW-1:0];

    assign end_sum = SW'(first) + SW'(count);

    always_comb
    begin
        gpos = '0;
        for (int p = 0; p < WB; p++)
        begin
            gpos         = SW'({word_idx, bca_pkg::POS_W'(p)});
            mark_mask[p] = (gpos >= SW'(first)) && (gpos < end_sum);
        end
    end

endmodule

// ----- tb/tb_bitmap_contiguous_allocator.sv -----
`timescale 1ns / 100ps

module tb_bitmap_contiguous_allocator;
    import bca_pkg::*;

    localparam int UNITS      = UNITS_DEFAULT;
    localparam int STALL_MAX  = 2000;
    localparam int GAP_PCT    = 22;
    localparam int ITEMS_RAND = 1200;
    localparam int PHASES     = 6;

    typedef struct {
        bit                     is_cfg;
        req_t                   item;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [ADDR_W-1:0]      reg_val;
    } job_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    req_t                   req;
    logic                   done;
    rsp_t                   rsp;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]      cfg_data;

    job_t job_q[$];
    rsp_t grant_q[$];

    // allocator shadow state
    logic [UNITS-1:0]   unit_used  = '0;
    logic [ADDR_W-1:0]  region_base = BASE_RESET;
    logic [SHIFT_W-1:0] unit_log2   = SHIFT_RESET;

    int n_launched   = 0;
    int n_checked    = 0;
    int n_alloc_req  = 0;
    int n_reserve_req = 0;
    int n_granted    = 0;
    int n_refused    = 0;
    int n_cfg_writes = 0;
    int mismatches   = 0;
    int stall_cycles = 0;

    bitmap_contiguous_allocator #(
        .UNITS (UNITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] unit_to_addr(input int idx);
        return region_base + (ADDR_W'(idx) << unit_log2);
    endfunction

    function automatic void mark_units(input int first, input int n);
        for (int k = 0; k < n && first + k < UNITS; k++)
        begin
            unit_used[first + k] = 1'b1;
        end
    endfunction

    function automatic rsp_t first_fit_grant(input req_t r);
        rsp_t res;
        int   run;
        int   run_start;
        bit   found;
        res       = '0;
        run       = 0;
        run_start = 0;
        found     = 1'b0;
        if (r.cmd == CMD_ALLOC)
        begin
            if (r.count == 0)
            begin
                res.ok      = 1'b1;
                res.address = unit_to_addr(0);
            end
            else
            begin
                for (int u = 0; u < UNITS && !found; u++)
                begin
                    if (unit_used[u])
                    begin
                        run       = 0;
                        run_start = u + 1;
                    end
                    else
                    begin
                        run++;
                        if (run == int'(r.count))
                            found = 1'b1;
                    end
                end
                if (found)
                begin
                    mark_units(run_start, int'(r.count));
                    res.ok          = 1'b1;
                    res.found_index = FOUND_W'(run_start);
                    res.address     = unit_to_addr(run_start);
                end
            end
        end
        else if (int'(r.start_index) < UNITS)
        begin
            mark_units(int'(r.start_index), int'(r.count));
            res.ok          = 1'b1;
            res.found_index = r.start_index;
            res.address     = unit_to_addr(int'(r.start_index));
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    task automatic add_item(input logic cmd, input int count, input int first);
        job_t j;
        j                  = '{default: '0};
        j.item.cmd         = cmd;
        j.item.count       = COUNT_W'(count);
        j.item.start_index = START_W'(first);
        job_q.push_back(j);
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] sel, input logic [ADDR_W-1:0] val);
        job_t j;
        j         = '{default: '0};
        j.is_cfg  = 1'b1;
        j.reg_sel = sel;
        j.reg_val = val;
        job_q.push_back(j);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        job_t j;
        logic go;
        logic we;
        int   gap;
        if (!rst_n)
        begin
            start     <= 1'b0;
            req       <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            go  = start && busy;
            we  = 1'b0;
            gap = (n_launched >= 500 && n_launched < 750) ? 0 : GAP_PCT;
            if (!go && job_q.size() > 0)
            begin
                if (job_q[0].is_cfg)
                begin
                    if (!start && !busy && !done && grant_q.size() == 0)
                    begin
                        j = job_q.pop_front();
                        we = 1'b1;
                        cfg_index <= j.reg_sel;
                        cfg_data  <= j.reg_val;
                    end
                end
                else if ($urandom_range(99) >= gap)
                begin
                    j = job_q.pop_front();
                    go = 1'b1;
                    req <= j.item;
                    n_launched++;
                end
            end
            start  <= go;
            cfg_we <= we;
        end
    end

    // monitor and scoreboard
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        rsp_t want;
        rsp_t pred;
        if (!rst_n)
        begin
            unit_used    = '0;
            region_base  = BASE_RESET;
            unit_log2    = SHIFT_RESET;
            stall_cycles = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                n_cfg_writes++;
                if (cfg_index == REG_BASE_ADDRESS)
                    region_base = cfg_data;
                else
                    unit_log2 = cfg_data[SHIFT_W-1:0];
            end
            if (done)
            begin
                if (grant_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual %0h", $time, rsp);
                end
                else
                begin
                    want = grant_q.pop_front();
                    n_checked++;
                    check_field("ok", 32'(want.ok), 32'(rsp.ok));
                    check_field("found_index", 32'(want.found_index), 32'(rsp.found_index));
                    check_field("address", want.address, rsp.address);
                end
            end
            if (start && !busy)
            begin
                pred = first_fit_grant(req);
                grant_q.push_back(pred);
                if (req.cmd == CMD_ALLOC)
                    n_alloc_req++;
                else
                    n_reserve_req++;
                if (pred.ok)
                    n_granted++;
                else
                    n_refused++;
            end
            if ((start && !busy) || done || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (stall_cycles >= STALL_MAX);
        $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        rst_n = 1'b0;

        // directed: reset config
        add_item(CMD_ALLOC, 0, 0);
        add_item(CMD_ALLOC, 2047, 1023);
        add_item(CMD_ALLOC, 1025, 0);
        add_item(CMD_RESERVE, 0, 0);
        add_item(CMD_RESERVE, 0, 1023);
        // fence off 127-unit runs so the only 128-unit run ends at the last unit
        for (int k = 1; k <= 7; k++)
            add_item(CMD_RESERVE, 1, k * 128 - 1);
        add_item(CMD_ALLOC, 128, 0);
        add_item(CMD_ALLOC, 1, 0);
        add_item(CMD_RESERVE, 2047, 1023);
        add_item(CMD_RESERVE, 2, 2);
        add_item(CMD_ALLOC, 2, 0);
        add_item(CMD_ALLOC, 1, 0);
        add_item(CMD_ALLOC, 127, 0);
        add_item(CMD_RESERVE, 24, 1000);
        add_item(CMD_ALLOC, 1024, 682);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin add_cfg(REG_BASE_ADDRESS, '0); add_cfg(REG_UNIT_SHIFT, 0); end
                1: begin add_cfg(REG_UNIT_SHIFT, 16); add_cfg(REG_BASE_ADDRESS, '1); end
                2: begin add_cfg(REG_BASE_ADDRESS, $urandom()); add_cfg(REG_UNIT_SHIFT, 31); end
                3:
                begin
                    add_cfg(REG_UNIT_SHIFT, $urandom());
                    add_cfg(REG_BASE_ADDRESS, $urandom());
                end
                4:
                begin
                    add_cfg(REG_BASE_ADDRESS, 32'h8000_0000 | $urandom());
                    add_cfg(REG_UNIT_SHIFT, 12);
                end
                default:
                begin
                    add_cfg(REG_BASE_ADDRESS, $urandom());
                    add_cfg(REG_UNIT_SHIFT, $urandom_range(0, 16));
                end
            endcase
            for (int i = 0; i < ITEMS_RAND / PHASES; i++)
            begin
                r = $urandom_range(99);
                if (r < 12)
                    add_item(CMD_ALLOC, 0, $urandom_range(1023));
                else if (r < 48)
                    add_item(CMD_ALLOC, $urandom_range(1, 2), $urandom_range(1023));
                else if (r < 56)
                    add_item(CMD_ALLOC, $urandom_range(3, 16), $urandom_range(1023));
                else if (r < 66)
                    add_item(CMD_ALLOC, $urandom_range(17, 2047), $urandom_range(1023));
                else if (r < 94)
                    add_item(CMD_RESERVE, $urandom_range(0, 2), $urandom_range(1023));
                else
                    add_item(CMD_RESERVE, $urandom_range(0, 2047), $urandom_range(960, 1023));
            end
        end

        // closing: fill the map completely
        add_item(CMD_RESERVE, 2047, 0);
        add_item(CMD_ALLOC, 1, 0);
        add_item(CMD_ALLOC, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (job_q.size() > 0 || start || grant_q.size() > 0)
            @(posedge clk);
        repeat (2 * 32 + 16) @(posedge clk);

        if (grant_q.size() != 0)
        begin
            mismatches++;
            $display("%0t: results missing: expected %0d more, actual 0", $time, grant_q.size());
        end

        $display("Checked %0d results: %0d allocate and %0d reserve items, %0d config writes",
                 n_checked, n_alloc_req, n_reserve_req, n_cfg_writes);
        $display("Granted %0d, refused %0d, %0d mismatches", n_granted, n_refused, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
